// File: hw/rtl/alist_pkg.sv
// Shared types and constants for the array list block.
// Holds the request and status codes and the command struct sent along the cell row.
// Depends on nothing; imported by alist_cell and array_list_insert_delete.
`default_nettype none

package alist_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int FUNC_W    = 2;
   localparam int POS_W     = 5;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;
   localparam int IDX_OUT_W = 4;

   // Operation selector carried in req_tuser.
   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT       = 2'd0,
      FN_DELETE       = 2'd1,
      FN_DELETE_VALUE = 2'd2,
      FN_READ         = 2'd3
   } func_type;

   // Outcome of a request, carried in rsp_tuser.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // Update command broadcast to every cell; each bit is already qualified.
   typedef struct packed {
      logic ins;      // insert at the point, cells above move up
      logic del_pos;  // delete at the point, cells from there move down
      logic del_val;  // delete first match, cells from the match move down
   } cell_cmd_type;

endpackage : alist_pkg

`default_nettype wire

// File: hw/rtl/array_list_insert_delete.sv
// Array list with insert, delete by position, delete by value and read.
// The response is registered and appears in the cycle after the request transaction.
// Throughput: one request per cycle unless rsp_tready stalls the response; every cell
// updates in the same cycle, and the cycle time is set by the first-match chain that
// runs through all CAPACITY cells. Reset clears the live count and the response valid;
// stored entries are left as they are and are never read before being written.
`default_nettype none

module array_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [4:0] position, [36:5] value, rest zero
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [4:0] count, [36:5] data, [40:37] index, rest zero
   output logic [1:0]       rsp_tuser    // [1:0] status
);
   import alist_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request fields.
   func_type              req_func;
   logic [POS_W-1:0]      req_pos;
   logic [VALUE_W-1:0]    req_value;
   logic                  req_fire;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      count_ext;

   // List state and response registers.
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic [VALUE_W-1:0]    rsp_data_ff;
   logic [VALUE_W-1:0]    rsp_data_in;
   logic [IDX_W-1:0]      rsp_idx_ff;
   logic [IDX_W-1:0]      rsp_idx_in;

   // Cell row wiring.
   cell_cmd_type          cmd;
   logic [VALUE_W-1:0]    cell_q   [CAPACITY];
   logic                  hit_chain[CAPACITY+1];
   logic [IDX_W-1:0]      idx_chain[CAPACITY+1];
   logic                  full;
   logic                  pos_live;
   logic [VALUE_W-1:0]    rd_data;

   assign req_func  = func_type'(req_tuser);
   assign req_pos   = req_tdata[POS_W-1:0];
   assign req_value = req_tdata[POS_W +: VALUE_W];

   // The response register frees as soon as its transaction completes.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign pos_ext   = CMP_W'(req_pos);
   assign count_ext = CMP_W'(count_ff);
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign pos_live  = pos_ext < count_ext;
   assign rd_data   = cell_q[pos_ext[IDX_W-1:0]];

   // Qualified commands for the cell row; a failing request changes nothing.
   always_comb begin
      cmd.ins     = req_fire && (req_func == FN_INSERT) && !full && (pos_ext <= count_ext);
      cmd.del_pos = req_fire && (req_func == FN_DELETE) && pos_live;
      cmd.del_val = req_fire && (req_func == FN_DELETE_VALUE) && hit_chain[CAPACITY];
   end

   // The row of cells, chained for neighbour moves and the first-match search.
   assign hit_chain[0] = 1'b0;
   assign idx_chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_q;
      logic [VALUE_W-1:0] right_q;

      if (i == 0) begin : g_first
         assign left_q = cell_q[i];
      end else begin : g_mid_l
         assign left_q = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_q = cell_q[i];
      end else begin : g_mid_r
         assign right_q = cell_q[i+1];
      end

      alist_cell #(
         .INDEX (i),
         .CMP_W (CMP_W),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .point   (pos_ext),
         .count   (count_ext),
         .value   (req_value),
         .left_q  (left_q),
         .right_q (right_q),
         .hit_in  (hit_chain[i]),
         .idx_in  (idx_chain[i]),
         .entry_q (cell_q[i]),
         .hit_out (hit_chain[i+1]),
         .idx_out (idx_chain[i+1])
      );
   end

   // Status, count and response payload for the request being taken.
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_data_in   = '0;
         rsp_idx_in    = '0;
         unique case (req_func)
            FN_INSERT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else if (!cmd.ins) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FN_DELETE: begin
               if (!pos_live) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  rsp_data_in = rd_data;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            FN_DELETE_VALUE: begin
               if (!hit_chain[CAPACITY]) begin
                  rsp_status_in = ST_MISSING;
               end else begin
                  rsp_data_in = req_value;
                  rsp_idx_in  = idx_chain[CAPACITY];
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            FN_READ: begin
               if (!pos_live) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  rsp_data_in = rd_data;
               end
            end
            default: begin
               rsp_status_in = ST_RANGE;
            end
         endcase
      end
   end

   // Control state is reset; the response payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   // Pack the response transaction.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, IDX_OUT_W'(rsp_idx_ff), rsp_data_ff, COUNT_W'(count_ff)};

   // The live count never exceeds the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("live count above capacity");

   // Every request transaction yields a response in the next cycle.
   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("response missing after request");

   // The count moves only when a request is taken.
   a_count_idle : assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a request");

   // A failed request leaves the count unchanged.
   a_fail_no_change : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_status_ff == ST_OK) || (count_ff == $past(count_ff)))
      else $error("failed request changed the count");

endmodule : array_list_insert_delete

`default_nettype wire

// File: hw/rtl/alist_cell.sv
// One storage cell of the list row: holds one entry and takes data from a neighbour.
// Also forms one link of the first-match chain used by delete by value.
// Depends on alist_pkg.
`default_nettype none

module alist_cell #(
   parameter int INDEX = 0,
   parameter int CMP_W = 6,
   parameter int IDX_W = 4
) (
   input  wire logic                       clock,
   input  wire alist_pkg::cell_cmd_type    cmd,
   input  wire logic [CMP_W-1:0]           point,
   input  wire logic [CMP_W-1:0]           count,
   input  wire logic [alist_pkg::VALUE_W-1:0] value,
   input  wire logic [alist_pkg::VALUE_W-1:0] left_q,
   input  wire logic [alist_pkg::VALUE_W-1:0] right_q,
   input  wire logic                       hit_in,
   input  wire logic [IDX_W-1:0]           idx_in,
   output logic [alist_pkg::VALUE_W-1:0]   entry_q,
   output logic                            hit_out,
   output logic [IDX_W-1:0]                idx_out
);
   import alist_pkg::*;

   localparam logic [CMP_W-1:0] MY_POS = CMP_W'(INDEX);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               live;
   logic               match;

   // Match only against live entries; the chain keeps the first one seen.
   assign live    = MY_POS < count;
   assign match   = live && (entry_ff == value);
   assign hit_out = hit_in | match;
   assign idx_out = hit_in ? idx_in : (match ? IDX_W'(INDEX) : '0);
   assign entry_q = entry_ff;

   // Next entry: write the new value, move up from the left, or move down from the right.
   always_comb begin
      priority if (cmd.ins && (MY_POS == point)) begin
         entry_in = value;
      end else if (cmd.ins && (MY_POS > point)) begin
         entry_in = left_q;
      end else if ((cmd.del_pos && (MY_POS >= point)) || (cmd.del_val && hit_out)) begin
         entry_in = right_q;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule : alist_cell

`default_nettype wire
